/* design/rrq_pkg.sv */
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types and constants of the round-robin ready queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

  // default geometry
  localparam int unsigned DepthDef  = 16;
  localparam int unsigned IdBitsDef = 8;

  // fixed request and result field widths
  localparam int unsigned OpBits     = 2;
  localparam int unsigned TidBits    = 8;
  localparam int unsigned StatusBits = 3;
  localparam int unsigned LenBits    = 5;

  typedef enum logic [OpBits-1:0] {
    OP_ADMIT  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEXT   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [StatusBits-1:0] {
    STAT_DONE     = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NULL     = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch request and the match of its id against the occupied cells
    logic update;   // compact the row and register the result
  } rrq_cmd_t;

endpackage

/* design/round_robin_ready_queue.sv */
// ----------------------------------------------------------------------------
// round_robin_ready_queue
// Ordered round-robin ready queue of thread ids with admit, remove, next, clear.
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low; it
//   carries opcode_i (admit, remove, next, clear) and thread_id_i
//   (id 0 is null and ignored by admit and remove)
//   every request gives exactly one result: thread_out_o, status_o and
//   length_o are valid for the single cycle in which done_o is high
// sequence
//   the cycle after acceptance is the update cycle (busy high), in which the
//   cell row is compacted and/or the tail written, per opcode; the result strobe
//   follows in the next cycle, when a new request may already be accepted;
//   the compare against the occupied cells is registered at acceptance and the
//   compaction over the cell row is done in the update cycle
// reset
//   rst_ni clears the queue length and the sequencer; cell contents are
//   never read above the length and need no clearing
// the receiver cannot stall: done_o is a one-cycle strobe
// ----------------------------------------------------------------------------
module round_robin_ready_queue
  import rrq_pkg::*;
#(
  parameter int unsigned DEPTH   = DepthDef,
  parameter int unsigned ID_BITS = IdBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request side
  input  logic                  start,
  output logic                  busy,
  input  logic [OpBits-1:0]     opcode_i,
  input  logic [TidBits-1:0]    thread_id_i,
  // result side
  output logic                  done_o,
  output logic [TidBits-1:0]    thread_out_o,
  output logic [StatusBits-1:0] status_o,
  output logic [LenBits-1:0]    length_o
);

  rrq_cmd_t cmd;

  // sequencer: capture, update, strobe
  rrq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // cell row with match, compaction and tail append
  rrq_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (opcode_i),
    .thread_id_i  (thread_id_i),
    .thread_out_o (thread_out_o),
    .status_o     (status_o),
    .length_o     (length_o)
  );

  localparam logic [31:0] DepthWide = 32'(DEPTH);

  // accepted request always enters the update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not enter update cycle");

  // update cycle is followed by exactly one result strobe and a free port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("missing result strobe after update");

  // a popped thread only comes with a successful status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (thread_out_o != '0) |-> status_o == STAT_DONE)
    else $error("thread returned with error status");

  // empty on next means the queue length is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_EMPTY) |-> length_o == '0)
    else $error("empty status with nonzero length");

  // dropped admit only when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_FULL) |-> length_o == DepthWide[LenBits-1:0])
    else $error("full status while queue not full");

endmodule

/* design/rrq_ctrl.sv */
// ----------------------------------------------------------------------------
// rrq_ctrl
// Request sequencer: capture cycle, then update cycle, then result strobe.
// ----------------------------------------------------------------------------
module rrq_ctrl
  import rrq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output rrq_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    done_d = cmd_o.update;
  end

  assign busy   = (state_q == ST_UPDATE);
  assign done_o = done_q;

endmodule

/* design/rrq_datapath.sv */
// ----------------------------------------------------------------------------
// rrq_datapath
// Row of id cells with parallel match, compaction on delete and tail append.
// ----------------------------------------------------------------------------
module rrq_datapath
  import rrq_pkg::*;
#(
  parameter int unsigned DEPTH   = DepthDef,
  parameter int unsigned ID_BITS = IdBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rrq_cmd_t              cmd_i,
  input  logic [OpBits-1:0]     opcode_i,
  input  logic [TidBits-1:0]    thread_id_i,
  output logic [TidBits-1:0]    thread_out_o,
  output logic [StatusBits-1:0] status_o,
  output logic [LenBits-1:0]    length_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [ID_BITS-1:0] cells_q [DEPTH];
  logic [ID_BITS-1:0] cells_d [DEPTH];
  logic [ID_BITS-1:0] shifted [DEPTH];
  logic [CW-1:0]      count_q, count_d;

  logic [DEPTH-1:0]   match_q, match_d;
  opcode_e            op_q;
  logic [ID_BITS-1:0] id_q;
  logic [ID_BITS-1:0] id_in;
  logic [31:0]        id_wide;

  logic [TidBits-1:0] thread_q, thread_d;
  status_e            status_q, status_d;

  logic               found;
  logic               full;
  logic [DEPTH-1:0]   ge;
  logic [DEPTH-1:0]   shift_pos;
  logic               wr_en;
  logic [CW-1:0]      wr_idx;
  logic [31:0]        head_wide;
  logic [31:0]        len_wide;

  // request id taken in its low ID_BITS bits
  assign id_wide = {24'd0, thread_id_i};
  assign id_in   = id_wide[ID_BITS-1:0];

  // parallel compare against the occupied cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (cells_q[i] == id_in) && (CW'(i) < count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      match_q <= match_d;
      op_q    <= opcode_e'(opcode_i);
      id_q    <= id_in;
    end
  end

  // everything at or above the first match moves down one cell; on next, every cell does
  always_comb begin
    found = |match_q;
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        ge[i] = ge[i] | match_q[j];
      end
    end
    shift_pos = (op_q == OP_NEXT) ? {DEPTH{1'b1}} : ge;
    for (int i = 0; i < DEPTH; i++) begin
      shifted[i] = (shift_pos[i] && (i < DEPTH - 1)) ? cells_q[(i + 1) % DEPTH] : cells_q[i];
    end
  end

  assign full      = (count_q == CW'(DEPTH));
  assign head_wide = 32'(cells_q[0]);

  always_comb begin
    count_d  = count_q;
    thread_d = '0;
    status_d = STAT_DONE;
    wr_en    = 1'b0;
    wr_idx   = count_q;
    for (int i = 0; i < DEPTH; i++) begin
      cells_d[i] = cells_q[i];
    end
    case (op_q)
      OP_ADMIT: begin
        if (id_q == '0) begin
          status_d = STAT_NULL;
        end else if (found) begin
          // move to tail: compact, then rewrite the last occupied cell
          for (int i = 0; i < DEPTH; i++) begin
            cells_d[i] = shifted[i];
          end
          wr_en  = 1'b1;
          wr_idx = count_q - CW'(1);
        end else if (full) begin
          status_d = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_idx  = count_q;
          count_d = count_q + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (id_q == '0) begin
          status_d = STAT_NULL;
        end else if (!found) begin
          status_d = STAT_NOTFOUND;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            cells_d[i] = shifted[i];
          end
          count_d = count_q - CW'(1);
        end
      end
      OP_NEXT: begin
        if (count_q == '0) begin
          status_d = STAT_EMPTY;
        end else begin
          thread_d = head_wide[TidBits-1:0];
          for (int i = 0; i < DEPTH; i++) begin
            cells_d[i] = shifted[i];
          end
          count_d = count_q - CW'(1);
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (wr_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CW'(i) == wr_idx) begin
          cells_d[i] = id_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_q[i] <= cells_d[i];
      end
      thread_q <= thread_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.update) begin
      count_q <= count_d;
    end
  end

  assign len_wide     = 32'(count_q);
  assign thread_out_o = thread_q;
  assign status_o     = status_q;
  assign length_o     = len_wide[LenBits-1:0];

endmodule

/* dv/round_robin_ready_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_ready_queue_tb
// Self-checking bench for the ready queue: directed corner requests, then
// random admit/remove/next/clear traffic with random idle gaps, each result
// compared against a shadow queue kept in the bench.
// ----------------------------------------------------------------------------
module round_robin_ready_queue_tb;
  import rrq_pkg::*;

  localparam int unsigned QDepth = DepthDef;

  // expected result of one request
  typedef struct {
    logic [TidBits-1:0] thread;
    status_e            status;
    logic [LenBits-1:0] length;
  } queue_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [OpBits-1:0]     opcode_i;
  logic [TidBits-1:0]    thread_id_i;
  logic                  done_o;
  logic [TidBits-1:0]    thread_out_o;
  logic [StatusBits-1:0] status_o;
  logic [LenBits-1:0]    length_o;

  // shadow of the queue contents, head at index 0
  logic [TidBits-1:0] shadow_ids[$];
  // results still owed by the block, oldest first
  queue_result_t      pending_results[$];
  int unsigned        mismatch_count;
  // when set, requests go back to back with no idle cycles
  bit                 burst_mode;

  round_robin_ready_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .thread_id_i (thread_id_i),
    .done_o      (done_o),
    .thread_out_o(thread_out_o),
    .status_o    (status_o),
    .length_o    (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // remove the first copy of tid from the shadow queue, report whether found
  function automatic bit shadow_delete(input logic [TidBits-1:0] tid);
    for (int i = 0; i < shadow_ids.size(); i++) begin
      if (shadow_ids[i] == tid) begin
        shadow_ids.delete(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // apply one accepted request to the shadow queue and queue up its result
  function automatic void predict_queue_op(input opcode_e op,
                                           input logic [TidBits-1:0] tid);
    queue_result_t res;
    logic [IdBitsDef-1:0] id;
    bit had;
    id         = tid[IdBitsDef-1:0];
    res.thread = '0;
    res.status = STAT_DONE;
    case (op)
      OP_ADMIT: begin
        if (id == '0) begin
          res.status = STAT_NULL;
        end else begin
          // an id already queued moves to the tail, even when full
          had = shadow_delete(id);
          if (!had && shadow_ids.size() >= QDepth) res.status = STAT_FULL;
          else shadow_ids.push_back(id);
        end
      end
      OP_REMOVE: begin
        if (id == '0) res.status = STAT_NULL;
        else if (!shadow_delete(id)) res.status = STAT_NOTFOUND;
      end
      OP_NEXT: begin
        if (shadow_ids.size() == 0) res.status = STAT_EMPTY;
        else res.thread = shadow_ids.pop_front();
      end
      default: begin
        // clear ignores the id
        shadow_ids.delete();
      end
    endcase
    res.length = LenBits'(shadow_ids.size());
    pending_results.push_back(res);
  endfunction

  // send one request: random idle gap (none in burst mode), then hold start until accepted
  task automatic issue_request(input opcode_e op, input logic [TidBits-1:0] tid);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk_i);
      start       <= 1'b0;
      // junk on the fields while idle must be ignored
      opcode_i    <= OpBits'($urandom);
      thread_id_i <= TidBits'($urandom);
    end
    @(negedge clk_i);
    start       <= 1'b1;
    opcode_i    <= op;
    thread_id_i <= tid;
    // busy read here is the value before the edge, so acceptance is exact
    do @(posedge clk_i); while (busy);
    predict_queue_op(op, tid);
  endtask

  function automatic opcode_e pick_op(input int unsigned admit_pct,
                                      input int unsigned remove_pct,
                                      input int unsigned next_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < admit_pct) return OP_ADMIT;
    if (roll < admit_pct + remove_pct) return OP_REMOVE;
    if (roll < admit_pct + remove_pct + next_pct) return OP_NEXT;
    return OP_CLEAR;
  endfunction

  // every result strobe is checked against the oldest expectation
  always @(posedge clk_i) begin
    queue_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result strobe with no request outstanding");
      end else begin
        exp_res = pending_results.pop_front();
        if (thread_out_o !== exp_res.thread)
          flag_mismatch($sformatf("thread_out %0h, expected %0h",
                                  thread_out_o, exp_res.thread));
        if (status_o !== exp_res.status)
          flag_mismatch($sformatf("status %0d, expected %0d",
                                  status_o, exp_res.status));
        if (length_o !== exp_res.length)
          flag_mismatch($sformatf("length %0d, expected %0d",
                                  length_o, exp_res.length));
      end
    end
  end

  // empty-queue and null-id corners, move-to-tail on readmit, clear
  task automatic test_basic_corners();
    issue_request(OP_NEXT, 8'h00);     // next on empty
    issue_request(OP_REMOVE, 8'h05);   // remove on empty, not found
    issue_request(OP_ADMIT, 8'h00);    // null admit ignored
    issue_request(OP_REMOVE, 8'h00);   // null remove ignored
    issue_request(OP_ADMIT, 8'hFF);
    issue_request(OP_ADMIT, 8'h01);
    issue_request(OP_ADMIT, 8'hFF);    // already queued, moves to tail
    issue_request(OP_NEXT, 8'hAA);     // pops 1, id ignored
    issue_request(OP_CLEAR, 8'h55);    // id ignored
  endtask

  // fill to capacity, overflow, readmit while full, remove from the middle
  task automatic test_full_queue();
    for (int k = 0; k < QDepth; k++) issue_request(OP_ADMIT, TidBits'(k * 16 + 1));
    issue_request(OP_ADMIT, 8'hAA);    // new id on full queue, dropped
    issue_request(OP_ADMIT, 8'h11);    // existing id on full queue, moves
    issue_request(OP_REMOVE, 8'h51);
    issue_request(OP_REMOVE, 8'h51);   // second time not found
    issue_request(OP_NEXT, 8'h00);
  endtask

  // small id pool, admit heavy, so the queue fills and ids hit often
  task automatic test_random_churn(input int unsigned n_req);
    logic [TidBits-1:0] tid;
    int unsigned roll;
    for (int n = 0; n < n_req; n++) begin
      if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
      roll = $urandom_range(0, 99);
      if (roll < 90) tid = TidBits'($urandom_range(1, 20));
      else if (roll < 95) tid = '0;
      else tid = TidBits'($urandom);
      issue_request(pick_op(50, 20, 28), tid);
    end
  endtask

  // full id range with occasional reuse of queued ids
  task automatic test_random_mixed(input int unsigned n_req);
    logic [TidBits-1:0] tid;
    for (int n = 0; n < n_req; n++) begin
      if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
      if (shadow_ids.size() != 0 && $urandom_range(0, 2) == 0)
        tid = shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
      else
        tid = TidBits'($urandom);
      issue_request(pick_op(40, 25, 30), tid);
    end
  endtask

  initial begin
    int unsigned drain;
    rst_ni         = 1'b0;
    start          = 1'b0;
    opcode_i       = OP_ADMIT;
    thread_id_i    = '0;
    mismatch_count = 0;
    burst_mode     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_corners();
    test_full_queue();
    test_random_churn(800);
    test_random_mixed(600);

    @(negedge clk_i);
    start <= 1'b0;

    // wait for the last results, bounded
    drain = 0;
    while (pending_results.size() != 0 && drain < 1000) begin
      @(posedge clk_i);
      drain++;
    end
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    // then watch for stray strobes before the verdict
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
